@@ src/bdq_pkg.sv @@
// shared types and codes for the bounded deque with search
`timescale 1ns / 1ps

package bdq_pkg;

  // request kinds carried by in_kind
  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_FIND       = 3'd3,
    KIND_READ_AT    = 3'd4
  } kind_t;

  // result status codes carried by out_status
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FIND,
    S_RWAIT,
    S_OUT
  } state_t;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned COUNT_W = 5;

endpackage

@@ src/bounded_deque_with_search.sv @@
// bounded deque of signed 32-bit words kept in a ring memory, with linear search
`timescale 1ns / 1ps

// Bounded deque with search. Holds up to DEPTH signed 32-bit words in a ring
// memory with one write port and one registered read port. Each input word is a
// request (push front, push back, pop front, find value, read at position) and
// gives exactly one output word with status, data, position and the count after
// the request. Requests are handled one at a time by a small sequencer around a
// shared ring-address adder and one 32-bit equality compare; in_stall is high
// from the acceptance of a request until its result has been moved into the
// output register. Push, pop, unknown kinds and an out-of-range read go from
// S_EXEC straight to S_OUT, a read at a valid position waits in S_RWAIT for the
// memory word, and a find stays in S_FIND until a hit or the end of the live range;
// the memory read port delivers one entry per cycle to the compare. The output
// register lets the next request be accepted while a result still waits behind
// out_stall. No clearing pass is needed after reset: only entries inside the
// live range are ever read. Entries outside 0..15 of result_position and
// 0..31 of count are truncated to the port widths for DEPTH above 16.
module bounded_deque_with_search #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bdq_pkg::KIND_W-1:0]    in_kind,
  input  logic signed [bdq_pkg::WORD_W-1:0] in_value,
  input  logic [bdq_pkg::POS_W-1:0]     in_position,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bdq_pkg::KIND_W-1:0]    out_status,
  output logic signed [bdq_pkg::WORD_W-1:0] out_result_value,
  output logic [bdq_pkg::POS_W-1:0]     out_result_position,
  output logic [bdq_pkg::COUNT_W-1:0]   out_count
);

  import bdq_pkg::*;

  // ring index and count widths follow the depth
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  // common width wide enough for count, index and the port fields
  localparam int unsigned XW = CW + POS_W + 1;

  // sequencer
  state_t state_r, state_nxt;

  // ring bookkeeping
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // latched request
  logic [KIND_W-1:0] kind_r;
  logic [WORD_W-1:0] val_r;
  logic [POS_W-1:0]  pos_r;

  // search walk: issue index, and the index whose data sits in rd_data_r
  logic [CW-1:0] iss_r, iss_nxt;
  logic          chk_r, chk_nxt;
  logic [CW-1:0] chk_idx_r, chk_idx_nxt;

  // pending result
  status_t       res_status_r, res_status_nxt;
  logic [WORD_W-1:0] res_value_r, res_value_nxt;
  logic [CW-1:0] res_pos_r, res_pos_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] out_status_r;
  logic [WORD_W-1:0] out_value_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [COUNT_W-1:0] out_count_r;
  logic              out_load;

  // ring memory
  logic [WORD_W-1:0] mem [DEPTH];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data_r;

  // shared ring adder: (head + offset) mod DEPTH, offset never above DEPTH
  logic [CW-1:0] ring_off;
  logic [CW:0]   ring_sum;
  logic [CW:0]   ring_wrap;
  logic [AW-1:0] ring_idx;

  always_comb begin
    ring_sum  = (CW + 1)'(head_r) + (CW + 1)'(ring_off);
    ring_wrap = (ring_sum >= (CW + 1)'(DEPTH)) ? (ring_sum - (CW + 1)'(DEPTH)) : ring_sum;
    ring_idx  = ring_wrap[AW-1:0];
  end

  // helpers
  logic          accept;
  logic          full;
  logic          empty;
  logic          hit;
  logic          walk_end;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] count_x;
  logic [XW-1:0] res_pos_x;
  logic [AW-1:0] head_dec;

  assign accept    = in_valid && !in_stall;
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign hit       = chk_r && (rd_data_r == val_r);
  assign walk_end  = (iss_r == count_r);
  assign pos_x     = XW'(pos_r);
  assign count_x   = XW'(count_r);
  assign res_pos_x = XW'(res_pos_r);
  assign head_dec  = (head_r == '0) ? AW'(DEPTH - 1) : (head_r - AW'(1));
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        priority if (kind_r == KIND_FIND) begin
          state_nxt = S_FIND;
        end else if (kind_r == KIND_READ_AT && pos_x < count_x) begin
          state_nxt = S_RWAIT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_FIND: begin
        if (hit || walk_end) state_nxt = S_OUT;
      end
      S_RWAIT: state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath control and next values
  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    iss_nxt        = iss_r;
    chk_nxt        = chk_r;
    chk_idx_nxt    = chk_idx_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_pos_nxt    = res_pos_r;
    mem_we         = 1'b0;
    mem_waddr      = ring_idx;
    ring_off       = iss_r;
    out_valid_nxt  = out_load ? 1'b1 : (out_valid_r && out_stall);
    unique case (state_r)
      S_EXEC: begin
        res_status_nxt = ST_OK;
        res_value_nxt  = '0;
        res_pos_nxt    = '0;
        iss_nxt        = '0;
        chk_nxt        = 1'b0;
        unique case (kind_r)
          KIND_PUSH_FRONT: begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = head_dec;
              head_nxt  = head_dec;
              count_nxt = count_r + CW'(1);
            end
          end
          KIND_PUSH_BACK: begin
            ring_off = count_r;
            if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end
          KIND_POP_FRONT: begin
            ring_off = CW'(1);
            if (empty) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              count_nxt = count_r - CW'(1);
              // leaving the store empty puts the head back at zero
              head_nxt  = (count_r == CW'(1)) ? '0 : ring_idx;
            end
          end
          KIND_FIND: begin
            ring_off = '0;
          end
          KIND_READ_AT: begin
            ring_off = pos_x[CW-1:0];
            if (pos_x >= count_x) res_status_nxt = ST_RANGE;
          end
          default: begin
            ring_off = '0;
          end
        endcase
      end
      S_FIND: begin
        ring_off = iss_r;
        priority if (hit) begin
          res_status_nxt = ST_OK;
          res_value_nxt  = val_r;
          res_pos_nxt    = chk_idx_r;
        end else if (walk_end) begin
          res_status_nxt = ST_NOT_FOUND;
        end else begin
          iss_nxt     = iss_r + CW'(1);
          chk_nxt     = 1'b1;
          chk_idx_nxt = iss_r;
        end
      end
      S_RWAIT: begin
        res_value_nxt = rd_data_r;
      end
      default: begin
        ring_off = iss_r;
      end
    endcase
  end

  assign rd_addr = ring_idx;

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= val_r;
    rd_data_r <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      chk_r       <= 1'b0;
      iss_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      chk_r       <= chk_nxt;
      iss_r       <= iss_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      val_r  <= in_value;
      pos_r  <= in_position;
    end
    chk_idx_r    <= chk_idx_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_pos_r    <= res_pos_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_pos_r    <= res_pos_x[POS_W-1:0];
      out_count_r  <= count_x[COUNT_W-1:0];
    end
  end

  // one request at a time; results wait in the output word register
  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_result_value    = out_value_r;
  assign out_result_position = out_pos_r;
  assign out_count           = out_count_r;

  // count never goes past the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above capacity");

  // an empty store always has its head at zero
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> head_r == '0)
    else $error("empty store with nonzero head");

  // the search walk never issues past the live range
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIND |-> iss_r <= count_r)
    else $error("search index beyond count");

  // a new result word only appears out of the hand-off state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result word raised outside hand-off");

endmodule

@@ sim/tb_bounded_deque_with_search.sv @@
// testbench for the bounded deque with search: random request traffic checked against a deque model
`timescale 1ns / 1ps

module tb_bounded_deque_with_search;
  import bdq_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int          ITEM_TARGET = 1750;   // counted requests in the random part
  localparam int          MAX_IDLE    = 16;     // longest per-word gap on either side
  localparam int          LONG_HOLD   = 300;    // receiver back-pressure stretch, in cycles
  localparam int          HOLD_EVERY  = 500;    // results between long holds
  localparam int          STALL_LIMIT = 2000;   // cycles without any handshake before giving up
  localparam int          SETTLE      = 40;     // quiet cycles after the last result

  // kinds the block ignores, still answered with one result word
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = KIND_W'(int'(KIND_READ_AT) + 1);
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = '1;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
    bit                       wait_for_drain;   // sender holds this word until all results are in
  } deque_req_t;

  typedef struct {
    logic [KIND_W-1:0]        status;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
    logic [COUNT_W-1:0]       count;
  } deque_rsp_t;

  // clock, reset and dut ports; every input starts at a known value
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [KIND_W-1:0]        in_kind = '0;
  logic signed [WORD_W-1:0] in_value = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b1;
  logic [KIND_W-1:0]        out_status;
  logic signed [WORD_W-1:0] out_result_value;
  logic [POS_W-1:0]         out_result_position;
  logic [COUNT_W-1:0]       out_count;

  bounded_deque_with_search #(.DEPTH(DEPTH)) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_value            (in_value),
    .in_position         (in_position),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_result_value    (out_result_value),
    .out_result_position (out_result_position),
    .out_count           (out_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // request words waiting to be sent, and results owed by the block in order
  deque_req_t pending_requests[$];
  deque_rsp_t expected_results[$];
  int         error_count = 0;

  // deque model state: ring of words, index of the front entry, number held
  logic signed [WORD_W-1:0] deque_mem [DEPTH];
  int unsigned              deque_head = 0;
  int unsigned              deque_level = 0;

  // apply one accepted request to the model and queue the result it owes
  task automatic deque_apply(input deque_req_t req);
    deque_rsp_t  rsp;
    int unsigned idx;
    bit          found;
    rsp.status   = ST_OK;
    rsp.value    = '0;
    rsp.position = '0;
    found        = 1'b0;
    case (req.kind)
      KIND_PUSH_FRONT: begin
        if (deque_level >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          deque_head = (deque_head + DEPTH - 1) % DEPTH;
          deque_mem[deque_head] = req.value;
          deque_level++;
        end
      end
      KIND_PUSH_BACK: begin
        if (deque_level >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          deque_mem[(deque_head + deque_level) % DEPTH] = req.value;
          deque_level++;
        end
      end
      KIND_POP_FRONT: begin
        if (deque_level == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          deque_head = (deque_head + 1) % DEPTH;
          deque_level--;
          // an emptied store starts over at ring slot zero
          if (deque_level == 0) deque_head = 0;
        end
      end
      KIND_FIND: begin
        // first match counted from the front wins
        rsp.status = ST_NOT_FOUND;
        for (idx = 0; idx < deque_level; idx++) begin
          if (!found && deque_mem[(deque_head + idx) % DEPTH] == req.value) begin
            found        = 1'b1;
            rsp.status   = ST_OK;
            rsp.value    = req.value;
            rsp.position = POS_W'(idx);
          end
        end
      end
      KIND_READ_AT: begin
        if (req.position >= deque_level) begin
          rsp.status = ST_RANGE;
        end else begin
          rsp.value = deque_mem[(deque_head + req.position) % DEPTH];
        end
      end
      default: ;  // spare kinds change nothing
    endcase
    rsp.count = COUNT_W'(deque_level);
    expected_results.push_back(rsp);
  endtask

  // idle gap for one word: zero or 1..MAX_IDLE, by a per-phase percentage
  function automatic int draw_idle(input int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) return $urandom_range(1, MAX_IDLE);
    return 0;
  endfunction

  // idle intensity for the next phase, from none to heavy
  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 15;
      2:       return 50;
      default: return 90;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents the next pending word, holds it while stalled, and feeds
  // every accepted word to the model
  // ---------------------------------------------------------------------------
  bit         drv_busy = 1'b0;
  deque_req_t drv_req;
  int         drv_gap = 0;
  int         drv_idle_pct = 0;
  int         drv_sent = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      drv_busy = 1'b0;
      drv_gap  = 0;
      in_valid <= 1'b0;
    end else begin
      // in_valid is high exactly while drv_busy is set
      if (drv_busy && !in_stall) begin
        deque_apply(drv_req);
        drv_busy = 1'b0;
        drv_sent++;
        if (drv_sent % 150 == 0) drv_idle_pct = pick_idle_pct();
      end
      if (!drv_busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_requests.size() != 0 &&
                     !(pending_requests[0].wait_for_drain && expected_results.size() != 0)) begin
          drv_req  = pending_requests[0];
          pending_requests.delete(0);
          drv_busy = 1'b1;
          drv_gap  = draw_idle(drv_idle_pct);
        end
      end
      // one nonblocking update per signal per edge; valid stays up across back-to-back words
      in_valid <= drv_busy;
      if (drv_busy) begin
        in_kind     <= drv_req.kind;
        in_value    <= drv_req.value;
        in_position <= drv_req.position;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: takes result words, checks them against the oldest expectation,
  // and drives out_stall with short random waits plus an occasional long hold
  // ---------------------------------------------------------------------------
  int         rx_wait = 0;
  int         rx_hold = 0;
  int         rx_idle_pct = 0;
  int         rx_seen = 0;
  deque_rsp_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result word: status %0d value %0d position %0d count %0d",
                   $time, out_status, out_result_value, out_result_position, out_count);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (out_status !== want.status) begin
            error_count++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_status);
          end
          if (out_result_value !== want.value) begin
            error_count++;
            $display("%0t: result_value mismatch: expected %0d, actual %0d",
                     $time, want.value, out_result_value);
          end
          if (out_result_position !== want.position) begin
            error_count++;
            $display("%0t: result_position mismatch: expected %0d, actual %0d",
                     $time, want.position, out_result_position);
          end
          if (out_count !== want.count) begin
            error_count++;
            $display("%0t: count mismatch: expected %0d, actual %0d",
                     $time, want.count, out_count);
          end
        end
        rx_seen++;
        if (rx_seen % 150 == 0) rx_idle_pct = pick_idle_pct();
        // long hold: the block fills up and must stall its input
        if (rx_seen % HOLD_EVERY == 0) rx_hold = LONG_HOLD;
        rx_wait = draw_idle(rx_idle_pct);
      end else if (rx_hold > 0) begin
        rx_hold--;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= (rx_hold > 0 || rx_wait > 0);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run if neither channel moves a word for too long
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results still owed",
                 $time, quiet_cycles, expected_results.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus generation; tracks the fill level so that sequences can aim at
  // full and empty, and keeps recent pushed words so that finds can hit
  // ---------------------------------------------------------------------------
  int                       gen_level = 0;
  int                       gen_counted = 0;
  logic signed [WORD_W-1:0] recent_words[$];

  task automatic add_request(input logic [KIND_W-1:0] kind, input logic signed [WORD_W-1:0] value,
                             input logic [POS_W-1:0] position, input bit wait_for_drain);
    deque_req_t req;
    req.kind           = kind;
    req.value          = value;
    req.position       = position;
    req.wait_for_drain = wait_for_drain;
    pending_requests.push_back(req);
    if (kind <= KIND_READ_AT) gen_counted++;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (gen_level < DEPTH) begin
          gen_level++;
          recent_words.push_back(value);
          if (recent_words.size() > 24) recent_words.delete(0);
        end
      end
      KIND_POP_FRONT: if (gen_level > 0) gen_level--;
      default: ;
    endcase
  endtask

  // word mix: extremes, a few small values that repeat often, and random bits
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return -32'sd1;
      3, 4:    return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // search key: mostly a recently pushed word, else anything
  function automatic logic signed [WORD_W-1:0] pick_key();
    if (recent_words.size() != 0 && $urandom_range(0, 9) < 7)
      return recent_words[$urandom_range(0, recent_words.size() - 1)];
    return pick_word();
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if (gen_level > 0 && $urandom_range(0, 9) < 6) return POS_W'($urandom_range(0, gen_level - 1));
    return POS_W'($urandom);
  endfunction

  // any position, in range or not
  function automatic logic [POS_W-1:0] any_position();
    return POS_W'($urandom);
  endfunction

  // one of the kinds the block ignores
  function automatic logic [KIND_W-1:0] pick_spare();
    return KIND_W'($urandom_range(int'(KIND_SPARE_FIRST), int'(KIND_SPARE_LAST)));
  endfunction

  // push on either end, chosen at random
  function automatic logic [KIND_W-1:0] pick_push();
    return $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
  endfunction

  initial begin
    int  n;
    int  k;
    int  r;
    bit  drain_done;
    drain_done = 1'b0;

    // directed: empty-store answers first
    add_request(KIND_FIND,      32'sd0,        4'd0, 1'b0);
    add_request(KIND_READ_AT,   -32'sd1,       4'd0, 1'b0);
    add_request(KIND_POP_FRONT, 32'sh5A5A_5A5A, 4'hF, 1'b0);
    // extremes on both ends; front to back: 0, min, max, -1
    add_request(KIND_PUSH_BACK,  32'sh7FFF_FFFF, 4'hF, 1'b0);
    add_request(KIND_PUSH_FRONT, 32'sh8000_0000, 4'd0, 1'b0);
    add_request(KIND_PUSH_BACK,  -32'sd1,        4'hA, 1'b0);
    add_request(KIND_PUSH_FRONT, 32'sd0,         4'h5, 1'b0);
    // finds: match at the middle, at the back, and a miss
    add_request(KIND_FIND, 32'sh8000_0000, 4'd0, 1'b0);
    add_request(KIND_FIND, -32'sd1,        4'd0, 1'b0);
    add_request(KIND_FIND, 32'sh1234_5678, 4'd0, 1'b0);
    // reads: last live entry, first one past the end, top position
    add_request(KIND_READ_AT, 32'sd0, 4'd3, 1'b0);
    add_request(KIND_READ_AT, 32'sd0, 4'd4, 1'b0);
    add_request(KIND_READ_AT, 32'sd0, 4'hF, 1'b0);
    // spare kinds are answered but change nothing
    for (k = int'(KIND_SPARE_FIRST); k <= int'(KIND_SPARE_LAST); k++)
      add_request(KIND_W'(k), -32'sd1, 4'hF, 1'b0);
    // drain to empty; head must restart so read and push line up again
    for (k = 0; k < 4; k++) add_request(KIND_POP_FRONT, 32'sd0, 4'd0, 1'b0);
    add_request(KIND_READ_AT,   32'sd0,         4'd0, 1'b0);
    add_request(KIND_PUSH_BACK, 32'sh5555_5555, 4'd0, 1'b0);
    add_request(KIND_READ_AT,   32'sd0,         4'd0, 1'b0);

    // random part: runs of fills, drains, noise and mixed traffic
    gen_counted = 0;
    while (gen_counted < ITEM_TARGET) begin
      // one pause mid-run: sender waits until every result is back
      if (!drain_done && gen_counted >= ITEM_TARGET / 2) begin
        add_request(KIND_FIND, pick_key(), any_position(), 1'b1);
        drain_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          // fill past full so pushes get refused, then look around
          n = DEPTH - gen_level + $urandom_range(1, 3);
          for (k = 0; k < n; k++) add_request(pick_push(), pick_word(), any_position(), 1'b0);
          add_request(KIND_FIND,    pick_key(),  any_position(),  1'b0);
          add_request(KIND_READ_AT, pick_word(), pick_position(), 1'b0);
        end
        2: begin
          // pop past empty, then search and read the empty store
          n = gen_level + $urandom_range(1, 2);
          for (k = 0; k < n; k++) add_request(KIND_POP_FRONT, pick_word(), any_position(), 1'b0);
          add_request(KIND_FIND,    pick_key(),  any_position(), 1'b0);
          add_request(KIND_READ_AT, pick_word(), any_position(), 1'b0);
        end
        3: begin
          n = $urandom_range(1, 3);
          for (k = 0; k < n; k++)
            add_request(pick_spare(), $urandom, any_position(), 1'b0);
        end
        default: begin
          n = $urandom_range(8, 24);
          for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 30)      add_request(pick_push(),     pick_word(), any_position(),  1'b0);
            else if (r < 50) add_request(KIND_POP_FRONT,  pick_word(), any_position(),  1'b0);
            else if (r < 75) add_request(KIND_FIND,       pick_key(),  any_position(),  1'b0);
            else if (r < 97) add_request(KIND_READ_AT,    pick_word(), pick_position(), 1'b0);
            else add_request(pick_spare(), $urandom, any_position(), 1'b0);
          end
        end
      endcase
    end

    // reset, held low from the start and released on an edge
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every word to be sent and answered, then let things settle
    while (pending_requests.size() != 0 || drv_busy || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
